>>> sv/rcsfp_pkg.sv
package rcsfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int EV_W        = 2;
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int SUM_W       = 16;
    localparam int UPC_W       = 5;

    localparam logic [SUM_W-1:0]  SUM_INIT            = 16'hFFFF;
    localparam logic [BYTE_W-1:0] TICK_MAX            = 8'hFF;
    localparam logic [BYTE_W-1:0] GAP_TICKS_RST       = 8'd3;
    localparam logic [BYTE_W-1:0] CHANNEL_COMMAND_RST = 8'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COMMAND = 2'd1;

    // event codes
    localparam logic [EV_W-1:0] EV_CHANNEL = 2'd0;
    localparam logic [EV_W-1:0] EV_FRAME   = 2'd1;
    localparam logic [EV_W-1:0] EV_BADSUM  = 2'd2;

    // input kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_LENGTH   = 3'd0,
        PH_DATA     = 3'd1,
        PH_SUM_LOW  = 3'd2,
        PH_SUM_HIGH = 3'd3,
        PH_DISCARD  = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        U_NOP,
        U_TICK,
        U_GAP,
        U_LEN,
        U_DATA,
        U_SUML,
        U_SUMH,
        U_DISCARD,
        U_EMIT_STAT,
        U_CH_INIT,
        U_RD_LO,
        U_RD_HI,
        U_CAP_HI,
        U_EMIT_CH
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_IN,
        C_BYTE,
        C_DISPATCH,
        C_CHAN,
        C_LAST_CH
    } cond_t;

    typedef struct packed {
        logic                accept;
        logic                wait_out;
        uop_t                uop;
        cond_t               cond;
        logic [UPC_W-1:0]    target;
    } uword_t;

    // sequencer -> datapath
    typedef struct packed {
        logic accept;
        uop_t uop;
    } ctrl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic   in_valid;
        logic   is_tick;
        phase_t phase_eff;
        logic   chan_ok;
        logic   last_ch;
        logic   out_busy;
    } stat_t;

    // program addresses; the phase steps sit in phase order from A_PHASE on
    localparam logic [UPC_W-1:0] A_FETCH  = 5'd0;
    localparam logic [UPC_W-1:0] A_DECODE = 5'd1;
    localparam logic [UPC_W-1:0] A_TICK   = 5'd2;
    localparam logic [UPC_W-1:0] A_GAP    = 5'd3;
    localparam logic [UPC_W-1:0] A_PHASE  = 5'd4;
    localparam logic [UPC_W-1:0] A_DATA   = 5'd5;
    localparam logic [UPC_W-1:0] A_SUML   = 5'd6;
    localparam logic [UPC_W-1:0] A_SUMH   = 5'd7;
    localparam logic [UPC_W-1:0] A_DISC   = 5'd8;
    localparam logic [UPC_W-1:0] A_CHSEL  = 5'd9;
    localparam logic [UPC_W-1:0] A_STAT   = 5'd10;
    localparam logic [UPC_W-1:0] A_CHINIT = 5'd11;
    localparam logic [UPC_W-1:0] A_RDLO   = 5'd12;
    localparam logic [UPC_W-1:0] A_RDHI   = 5'd13;
    localparam logic [UPC_W-1:0] A_CAPHI  = 5'd14;
    localparam logic [UPC_W-1:0] A_EMIT   = 5'd15;
    localparam logic [UPC_W-1:0] A_LOOP   = 5'd16;

    // control store
    function automatic uword_t ucode(input logic [UPC_W-1:0] a);
        uword_t w;
        w = '{accept: 1'b0, wait_out: 1'b0, uop: U_NOP, cond: C_NEXT, target: A_FETCH};
        unique case (a)
            A_FETCH:  begin w.accept = 1'b1; w.cond = C_NO_IN; w.target = A_FETCH; end
            A_DECODE: begin w.cond = C_BYTE; w.target = A_GAP; end
            A_TICK:   begin w.uop = U_TICK; w.cond = C_ALWAYS; end
            A_GAP:    begin w.uop = U_GAP; w.cond = C_DISPATCH; w.target = A_PHASE; end
            A_PHASE:  begin w.uop = U_LEN; w.cond = C_ALWAYS; end
            A_DATA:   begin w.uop = U_DATA; w.cond = C_ALWAYS; end
            A_SUML:   begin w.uop = U_SUML; w.cond = C_ALWAYS; end
            A_SUMH:   begin w.uop = U_SUMH; w.cond = C_ALWAYS; w.target = A_CHSEL; end
            A_DISC:   begin w.uop = U_DISCARD; w.cond = C_ALWAYS; end
            A_CHSEL:  begin w.cond = C_CHAN; w.target = A_CHINIT; end
            A_STAT:   begin w.uop = U_EMIT_STAT; w.wait_out = 1'b1; w.cond = C_ALWAYS; end
            A_CHINIT: begin w.uop = U_CH_INIT; end
            A_RDLO:   begin w.uop = U_RD_LO; end
            A_RDHI:   begin w.uop = U_RD_HI; end
            A_CAPHI:  begin w.uop = U_CAP_HI; end
            A_EMIT:   begin w.uop = U_EMIT_CH; w.wait_out = 1'b1; w.cond = C_LAST_CH; end
            A_LOOP:   begin w.cond = C_ALWAYS; w.target = A_RDLO; end
            default:  begin w.cond = C_ALWAYS; end
        endcase
        return w;
    endfunction

endpackage

>>> sv/rcsfp_ram.sv
module rcsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 29
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/rcsfp_sequencer.sv
module rcsfp_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  rcsfp_pkg::stat_t stat,
    output rcsfp_pkg::ctrl_t ctrl
);

    import rcsfp_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           word;
    logic             stall;
    logic             take;

    assign word  = ucode(upc_reg);
    assign stall = word.wait_out && stat.out_busy;

    always_comb
    begin
        unique case (word.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !stat.in_valid;
            C_BYTE:     take = !stat.is_tick;
            C_DISPATCH: take = 1'b1;
            C_CHAN:     take = stat.chan_ok;
            C_LAST_CH:  take = stat.last_ch;
            default:    take = 1'b1;
        endcase
    end

    always_comb
    begin
        priority if (stall)
        begin
            upc_next = upc_reg;
        end
        else if (word.cond == C_DISPATCH)
        begin
            upc_next = word.target + UPC_W'(stat.phase_eff);
        end
        else if (take)
        begin
            upc_next = word.target;
        end
        else
        begin
            upc_next = upc_reg + UPC_W'(1);
        end
    end

    always_comb
    begin
        ctrl.accept = word.accept;
        ctrl.uop    = stall ? U_NOP : word.uop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> sv/rcsfp_datapath.sv
module rcsfp_datapath #(
    parameter int FRAME_MAX       = 32,
    parameter int HEADER_OVERHEAD = 3,
    parameter int CHANNEL_COUNT   = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rcsfp_pkg::ctrl_t                      ctrl,
    output rcsfp_pkg::stat_t                      stat,
    input  logic                                  s_tvalid,
    input  logic [rcsfp_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rcsfp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [rcsfp_pkg::EV_W-1:0]            m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    input  logic [rcsfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rcsfp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import rcsfp_pkg::*;

    localparam int BUF_DEPTH = FRAME_MAX - HEADER_OVERHEAD;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int CH_W      = $clog2(CHANNEL_COUNT + 1);
    localparam int POS_W     = $clog2(2 * CHANNEL_COUNT + 3);

    // configuration
    logic [BYTE_W-1:0] gap_reg, cmd_reg;

    // parser state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] idle_reg, idle_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  length_reg, length_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] trailer_reg, trailer_next;
    logic [BYTE_W-1:0] byte0_reg, byte0_next;
    logic [BUF_DEPTH-1:0] valid_reg, valid_next;
    logic              ok_reg, ok_next;
    logic              chan_reg, chan_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [BYTE_W-1:0] lo_reg, lo_next;
    logic [BYTE_W-1:0] hi_reg, hi_next;

    // latched input item
    logic              op_reg;
    logic [BYTE_W-1:0] byte_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [EV_W-1:0]   ev_reg, ev_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic              last_reg, last_next;

    logic              gap_hit;
    logic              len_ok;
    logic              out_busy;
    logic              last_ch;
    logic [POS_W-1:0]  rd_pos;
    logic              rd_in_range;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] ram_q;
    logic [BYTE_W-1:0] rd_byte;
    logic              ram_we;
    logic [31:0]       ch_wide;

    assign gap_hit  = idle_reg >= gap_reg;
    assign len_ok   = ({1'b0, byte_reg} <= 9'(FRAME_MAX)) && (byte_reg > 8'(HEADER_OVERHEAD));
    assign out_busy = out_valid_reg && !m_tready;
    assign ch_wide  = 32'(ch_reg);
    assign last_ch  = ch_wide == 32'(CHANNEL_COUNT - 1);

    // channel bytes live at buffer positions 2i+1 and 2i+2
    assign rd_pos      = POS_W'({ch_reg, 1'b0})
                       + ((ctrl.uop == U_RD_HI) ? POS_W'(2) : POS_W'(1));
    assign rd_in_range = 32'(rd_pos) < BUF_DEPTH;
    assign raddr       = AW'(rd_pos);
    assign rd_byte     = rd_ok_reg ? ram_q : '0;
    assign ram_we      = (ctrl.uop == U_DATA) && (32'(count_reg) < BUF_DEPTH);

    rcsfp_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        stat.in_valid  = s_tvalid;
        stat.is_tick   = (op_reg == OP_TICK);
        stat.phase_eff = gap_hit ? PH_LENGTH : phase_reg;
        stat.chan_ok   = ok_reg && chan_reg;
        stat.last_ch   = last_ch;
        stat.out_busy  = out_busy;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        idle_next      = idle_reg;
        count_next     = count_reg;
        length_next    = length_reg;
        sum_next       = sum_reg;
        trailer_next   = trailer_reg;
        byte0_next     = byte0_reg;
        valid_next     = valid_reg;
        ok_next        = ok_reg;
        chan_next      = chan_reg;
        ch_next        = ch_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ev_next        = ev_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        rd_ok_next     = rd_in_range && valid_reg[raddr];

        unique case (ctrl.uop)
            U_NOP: ;
            U_TICK:
            begin
                if (idle_reg != TICK_MAX)
                begin
                    idle_next = idle_reg + 8'd1;
                end
            end
            U_GAP:
            begin
                idle_next = '0;
            end
            U_LEN:
            begin
                if (len_ok)
                begin
                    count_next  = '0;
                    length_next = CNT_W'(byte_reg - 8'(HEADER_OVERHEAD));
                    sum_next    = SUM_INIT - {8'h00, byte_reg};
                    phase_next  = PH_DATA;
                end
                else
                begin
                    phase_next = PH_DISCARD;
                end
            end
            U_DATA:
            begin
                if (ram_we)
                begin
                    valid_next[count_reg[AW-1:0]] = 1'b1;
                end
                if (count_reg == '0)
                begin
                    byte0_next = byte_reg;
                end
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_reg - {8'h00, byte_reg};
                if (count_reg + CNT_W'(1) >= length_reg)
                begin
                    phase_next = PH_SUM_LOW;
                end
            end
            U_SUML:
            begin
                trailer_next = byte_reg;
                phase_next   = PH_SUM_HIGH;
            end
            U_SUMH:
            begin
                ok_next    = sum_reg == {byte_reg, trailer_reg};
                chan_next  = byte0_reg == cmd_reg;
                phase_next = PH_DISCARD;
            end
            U_DISCARD:
            begin
                phase_next = PH_DISCARD;
            end
            U_EMIT_STAT:
            begin
                out_valid_next = 1'b1;
                ev_next        = ok_reg ? EV_FRAME : EV_BADSUM;
                idx_next       = '0;
                val_next       = '0;
                last_next      = 1'b1;
            end
            U_CH_INIT:
            begin
                ch_next = '0;
            end
            U_RD_LO: ;
            U_RD_HI:
            begin
                lo_next = rd_byte;
            end
            U_CAP_HI:
            begin
                hi_next = rd_byte;
            end
            U_EMIT_CH:
            begin
                out_valid_next = 1'b1;
                ev_next        = EV_CHANNEL;
                idx_next       = ch_wide[IDX_W-1:0];
                val_next       = {hi_reg, lo_reg};
                last_next      = last_ch;
                ch_next        = ch_reg + CH_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= GAP_TICKS_RST;
            cmd_reg       <= CHANNEL_COMMAND_RST;
            phase_reg     <= PH_LENGTH;
            idle_reg      <= TICK_MAX;
            count_reg     <= '0;
            byte0_reg     <= '0;
            valid_reg     <= '0;
            ok_reg        <= 1'b0;
            chan_reg      <= 1'b0;
            ch_reg        <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_GAP_TICKS)
            begin
                gap_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_CHANNEL_COMMAND)
            begin
                cmd_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            idle_reg      <= idle_next;
            count_reg     <= count_next;
            byte0_reg     <= byte0_next;
            valid_reg     <= valid_next;
            ok_reg        <= ok_next;
            chan_reg      <= chan_next;
            ch_reg        <= ch_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept && s_tvalid)
        begin
            op_reg   <= s_tuser;
            byte_reg <= s_tdata;
        end
        length_reg  <= length_next;
        sum_reg     <= sum_next;
        trailer_reg <= trailer_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        ev_reg      <= ev_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ev_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - VAL_W - IDX_W){1'b0}}, val_reg, idx_reg};

endmodule

>>> sv/rc_serial_frame_parser_unit.sv
// A tick item passes the decode and tick steps, a byte item the decode, gap and phase
// steps, before the next item is taken. A trailer byte giving a status result shows
// it after the channel-select and status-emit steps. A channel frame trailer emits
// CHANNEL_COUNT results, paced by two buffer reads per channel on the single read port.
// rst_n is asynchronous and active low: parser to length phase, buffer reads
// as zero, gap_ticks 3, channel_command 64, no result pending.
module rc_serial_frame_parser_unit #(
    parameter int FRAME_MAX       = 32,
    parameter int HEADER_OVERHEAD = 3,
    parameter int CHANNEL_COUNT   = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rcsfp_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rcsfp_pkg::OUT_TDATA_W-1:0] m_tdata,   // [3:0] channel_index,
                                                         // [19:4] channel_value
    output logic [rcsfp_pkg::EV_W-1:0]        m_tuser,   // [1:0] event_res
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcsfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcsfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import rcsfp_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    assign s_tready  = ctrl.accept;
    assign cfg_ready = 1'b1;

    rcsfp_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    rcsfp_datapath #(
        .FRAME_MAX       (FRAME_MAX),
        .HEADER_OVERHEAD (HEADER_OVERHEAD),
        .CHANNEL_COUNT   (CHANNEL_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

>>> sv/rcsfp_checker.sv
module rcsfp_checker #(
    parameter int CHANNEL_COUNT = 14
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rcsfp_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [rcsfp_pkg::EV_W-1:0]        m_tuser,
    input logic                              m_tlast
);

    import rcsfp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNEL_COUNT - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == EV_CHANNEL || m_tuser == EV_FRAME || m_tuser == EV_BADSUM))
        else $error("unknown event code");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_CHANNEL |-> m_tlast && m_tdata == '0)
        else $error("status item not single and zero");

    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_CHANNEL && m_tlast |-> m_tdata[IDX_W-1:0] == LAST_IDX)
        else $error("last flag on wrong channel");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_CHANNEL && !m_tlast |-> !s_tready)
        else $error("input taken during channel burst");

endmodule

bind rc_serial_frame_parser_unit rcsfp_checker #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
) u_rcsfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> dv/rc_serial_frame_parser_unit_tb.sv
`timescale 1ns / 1ps

module rc_serial_frame_parser_unit_tb;

    import rcsfp_pkg::*;

    localparam int FRAME_LEN_MAX = 32;
    localparam int HDR_BYTES     = 3;
    localparam int CHANNELS      = 14;
    localparam int BUF_DEPTH     = FRAME_LEN_MAX - HDR_BYTES;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;

    // unused register slots, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

    typedef struct packed {
        logic [EV_W-1:0]  ev;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             lst;
    } parser_report_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [EV_W-1:0]        m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // parser mirror
    logic [7:0]     gap_limit;
    logic [7:0]     chan_cmd;
    phase_t         rx_phase;
    logic [7:0]     ticks_since_byte;
    logic [7:0]     payload_copy [BUF_DEPTH];
    logic [4:0]     payload_count;
    logic [4:0]     payload_len;
    logic [SUM_W-1:0] sum_left;
    logic [7:0]     sum_low;

    parser_report_t pending_reports [$];
    logic [7:0]     frame_bytes [BUF_DEPTH];
    int             mismatches = 0;
    int             items_sent = 0;
    int             hold_req   = 0;
    bit             quiet      = 1'b0;

    rc_serial_frame_parser_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void reset_model();
        gap_limit        = GAP_TICKS_RST;
        chan_cmd         = CHANNEL_COMMAND_RST;
        rx_phase         = PH_LENGTH;
        ticks_since_byte = TICK_MAX;
        for (int i = 0; i < BUF_DEPTH; i++)
            payload_copy[i] = 8'h00;
        payload_count    = '0;
        payload_len      = '0;
        sum_left         = '0;
        sum_low          = '0;
    endfunction

    function automatic logic [7:0] payload_at(input int pos);
        return (pos < BUF_DEPTH) ? payload_copy[pos] : 8'h00;
    endfunction

    function automatic void parse_step(input logic op, input logic [7:0] b);
        parser_report_t r;
        if (op == OP_TICK) begin
            if (ticks_since_byte != TICK_MAX)
                ticks_since_byte++;
        end
        else begin
            if (ticks_since_byte >= gap_limit)
                rx_phase = PH_LENGTH;
            ticks_since_byte = '0;
            case (rx_phase)
                PH_LENGTH:
                begin
                    if (b <= FRAME_LEN_MAX && b > HDR_BYTES) begin
                        payload_count = '0;
                        payload_len   = 5'(b - HDR_BYTES);
                        sum_left      = SUM_INIT - {8'h00, b};
                        rx_phase      = PH_DATA;
                    end
                    else
                        rx_phase = PH_DISCARD;
                end
                PH_DATA:
                begin
                    if (payload_count < BUF_DEPTH)
                        payload_copy[payload_count] = b;
                    payload_count++;
                    sum_left = sum_left - {8'h00, b};
                    if (payload_count >= payload_len)
                        rx_phase = PH_SUM_LOW;
                end
                PH_SUM_LOW:
                begin
                    sum_low  = b;
                    rx_phase = PH_SUM_HIGH;
                end
                PH_SUM_HIGH:
                begin
                    if (sum_left == {b, sum_low}) begin
                        if (payload_copy[0] == chan_cmd) begin
                            for (int i = 0; i < CHANNELS; i++) begin
                                r.ev  = EV_CHANNEL;
                                r.idx = IDX_W'(i);
                                r.val = {payload_at(2 * i + 2), payload_at(2 * i + 1)};
                                r.lst = (i == CHANNELS - 1);
                                pending_reports.push_back(r);
                            end
                        end
                        else
                            pending_reports.push_back('{EV_FRAME, '0, '0, 1'b1});
                    end
                    else
                        pending_reports.push_back('{EV_BADSUM, '0, '0, 1'b1});
                    rx_phase = PH_DISCARD;
                end
                default:
                    rx_phase = PH_DISCARD;
            endcase
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_reports
        parser_report_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: ev %0d ch %0d val %h last %b",
                             m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast);
            end
            else begin
                want = pending_reports.pop_front();
                if (m_tuser !== want.ev || m_tdata[3:0] !== want.idx ||
                    m_tdata[19:4] !== want.val || m_tlast !== want.lst) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp ev %0d ch %0d val %h last %b, ",
                                  "got ev %0d ch %0d val %h last %b"},
                                 want.ev, want.idx, want.val, want.lst,
                                 m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast);
                end
            end
        end
    end

    // result sink, with one long hold-off per request
    initial
    begin : sink
        int k;
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            m_tready <= quiet || ($urandom_range(99) >= 6);
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        if (!quiet && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        parse_step(op, b);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(OP_TICK, 8'($urandom));
    endtask

    // lead ticks, length byte, payload from frame_bytes, checksum trailer (low byte first)
    task automatic send_frame(input int len, input bit corrupt, input int lead);
        logic [SUM_W-1:0] sum;
        int               i;
        sum = SUM_INIT - SUM_W'(len);
        for (i = 0; i < len - HDR_BYTES; i++)
            sum = sum - {8'h00, frame_bytes[i]};
        if (corrupt)
            sum = sum ^ (16'h0001 << $urandom_range(15));
        send_ticks(lead);
        send_item(OP_BYTE, 8'(len));
        for (i = 0; i < len - HDR_BYTES + 2; i++) begin
            // short tick runs below the gap keep the frame alive
            if (gap_limit > 1 && $urandom_range(99) < 8)
                send_ticks($urandom_range(1, (gap_limit > 4) ? 3 : gap_limit - 1));
            if (i < len - HDR_BYTES)
                send_item(OP_BYTE, frame_bytes[i]);
            else if (i == len - HDR_BYTES)
                send_item(OP_BYTE, sum[7:0]);
            else
                send_item(OP_BYTE, sum[15:8]);
        end
    endtask

    function automatic void fill_payload();
        for (int i = 0; i < BUF_DEPTH; i++)
            frame_bytes[i] = 8'($urandom);
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_GAP_TICKS)
            gap_limit = val;
        else if (idx == REG_CHANNEL_COMMAND)
            chan_cmd = val;
    endtask

    task automatic set_config(input logic [7:0] gap, input logic [7:0] cmd);
        write_reg(REG_GAP_TICKS, gap);
        write_reg(REG_CHANNEL_COMMAND, cmd);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_full_channel_frame();
        fill_payload();
        frame_bytes[0] = chan_cmd;
        frame_bytes[1] = 8'h00;
        frame_bytes[2] = 8'h00;
        frame_bytes[3] = 8'hFF;
        frame_bytes[4] = 8'hFF;
        // counter is saturated out of reset; a tick must not wrap it
        send_ticks(1);
        send_frame(FRAME_LEN_MAX, 1'b0, 0);
        drain();
    endtask

    task automatic test_status_results();
        logic [7:0] bad_len [4];
        int         k;
        bad_len[0] = 8'd0;
        bad_len[1] = 8'(HDR_BYTES);
        bad_len[2] = 8'(FRAME_LEN_MAX + 1);
        bad_len[3] = 8'hFF;
        fill_payload();
        frame_bytes[0] = ~chan_cmd;
        send_frame(HDR_BYTES + 1, 1'b0, gap_limit);
        fill_payload();
        frame_bytes[0] = ~chan_cmd;
        send_frame(HDR_BYTES + 6, 1'b0, gap_limit);
        fill_payload();
        frame_bytes[0] = chan_cmd;
        send_frame(HDR_BYTES + 6, 1'b1, gap_limit);
        // no gap after the trailer: the whole next frame is dropped
        send_frame(HDR_BYTES + 1, 1'b0, 0);
        for (k = 0; k < 4; k++) begin
            send_ticks(gap_limit);
            send_item(OP_BYTE, bad_len[k]);
            send_item(OP_BYTE, 8'(HDR_BYTES + 1));
        end
        drain();
    endtask

    task automatic test_short_channel_frame();
        fill_payload();
        frame_bytes[0] = chan_cmd;
        send_frame(HDR_BYTES + 5, 1'b0, gap_limit);
        drain();
        set_config(gap_limit, 8'h00);
        fill_payload();
        frame_bytes[0] = 8'h00;
        send_frame(HDR_BYTES + 1, 1'b0, gap_limit);
        drain();
    endtask

    task automatic test_unused_registers();
        write_reg(REG_SPARE2, 8'($urandom));
        write_reg(REG_SPARE3, 8'($urandom));
        cfg_valid <= 1'b0;
        fill_payload();
        frame_bytes[0] = chan_cmd;
        send_frame(HDR_BYTES + 5, 1'b0, gap_limit);
        drain();
    endtask

    task automatic test_gap_extremes();
        int k;
        // zero gap: every byte is a length byte
        set_config(8'd0, CHANNEL_COMMAND_RST);
        send_item(OP_BYTE, 8'(FRAME_LEN_MAX));
        for (k = 0; k < 8; k++)
            send_item(k[0], 8'($urandom));
        drain();
        set_config(8'd1, 8'hFF);
        fill_payload();
        frame_bytes[0] = 8'hFF;
        send_frame(HDR_BYTES + 5, 1'b0, 1);
        drain();
        // longest gap: a few idle ticks do not restart framing
        set_config(8'hFF, 8'hFF);
        fill_payload();
        frame_bytes[0] = 8'hFF;
        send_frame(HDR_BYTES + 1, 1'b0, 4);
        drain();
    endtask

    task automatic test_random_traffic(input int n_items, input logic [7:0] gap,
                                       input logic [7:0] cmd, input bit calm);
        int stop_at;
        int pick;
        int len;
        int cnt;
        set_config(gap, cmd);
        quiet   = calm;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            fill_payload();
            len = ($urandom_range(1) == 1) ? FRAME_LEN_MAX
                                           : $urandom_range(HDR_BYTES + 1, FRAME_LEN_MAX);
            if (pick < 55)
                frame_bytes[0] = chan_cmd;
            if (pick < 80)
                send_frame(len, $urandom_range(99) < 10, gap_limit + $urandom_range(2));
            else if (pick < 88) begin
                // frame cut short, picked up by the next gap
                cnt = $urandom_range(0, len - 2);
                send_ticks(gap_limit);
                send_item(OP_BYTE, 8'(len));
                repeat (cnt) send_item(OP_BYTE, 8'($urandom));
            end
            else if (pick < 94) begin
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom), 8'($urandom));
            end
            else begin
                send_ticks(gap_limit);
                send_item(OP_BYTE, ($urandom_range(1) == 1) ? 8'($urandom_range(0, HDR_BYTES))
                                   : 8'($urandom_range(FRAME_LEN_MAX + 1, 255)));
                repeat ($urandom_range(0, 4)) send_item(OP_BYTE, 8'($urandom));
            end
        end
        drain();
        quiet = 1'b0;
    endtask

    task automatic test_output_stall();
        int k;
        hold_req <= hold_req + 1;
        for (k = 0; k < 2; k++) begin
            fill_payload();
            frame_bytes[0] = chan_cmd;
            send_frame(FRAME_LEN_MAX, 1'b0, gap_limit);
        end
        drain();
    endtask

    initial
    begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_full_channel_frame();
        test_status_results();
        test_short_channel_frame();
        test_unused_registers();
        test_gap_extremes();
        test_random_traffic(15, 8'd1, CHANNEL_COMMAND_RST, 1'b0);
        test_random_traffic(20, 8'd2, 8'($urandom), 1'b1);
        test_random_traffic(15, 8'($urandom_range(1, 5)), 8'hFF, 1'b0);
        test_output_stall();
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
sv/rcsfp_pkg.sv
sv/rcsfp_ram.sv
sv/rcsfp_sequencer.sv
sv/rcsfp_datapath.sv
sv/rc_serial_frame_parser_unit.sv
sv/rcsfp_checker.sv
dv/rc_serial_frame_parser_unit_tb.sv
